### rtl/core/cld_pkg.sv
// Shared types, character codes and helper functions of the content-length deframer.
`timescale 1ns / 1ps

package cld_pkg;

  typedef enum logic [2:0] {
    PH_KEY   = 3'd0,
    PH_SKIP  = 3'd1,
    PH_VALUE = 3'd2,
    PH_TAIL  = 3'd3,
    PH_REST  = 3'd4,
    PH_BODY  = 3'd5
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_BODY     = 2'd0;
  localparam kind_t KIND_EMPTY    = 2'd1;
  localparam kind_t KIND_MISSING  = 2'd2;
  localparam kind_t KIND_TOO_LONG = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] KEY_LEN = 4'd14;

  localparam int          CFG_ADDR_W        = 3;
  localparam logic        REG_MAX_BODY_LEN  = 1'b0;
  localparam logic [30:0] MAX_BODY_LEN_RST  = 31'h7FFF_FFFF;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] body_byte;
    logic       frame_last;
  } result_t;

  function automatic logic [7:0] key_char(logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h63;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h6C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    logic [7:0] r;
    r = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    logic r;
    r = (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    return r;
  endfunction

endpackage

### rtl/core/content_length_deframer_core.sv
// Top level of the content-length deframer: register port, parser and output buffering.
//
// Usage: a byte stream of frames enters on the in_ channel (in_valid, in_stall,
// in_byte), one byte per transfer. Each frame is a header block of CR LF lines
// closed by an empty line, then a body whose length is the first Content-Length
// header. Body bytes leave on the out_ channel with kind 0, the last one flagged
// by out_frame_last. An empty body gives one kind 1 item; a missing or negative
// length gives kind 2 and an overlong or too large length gives kind 3, after
// which header parsing starts again with the next byte.
// The largest accepted body length is written through the APB port at address 0.
// Results are registered: each leaves through the output register or the skid register.
// Throughput: one byte per cycle while in_stall is low; the parser state updates once per byte transfer.
// A two-entry output buffer (output register plus skid register) lets the block
// take one more byte while a result waits; in_stall rises when both are full.
// Reset clears the parser to the start of a frame, empties the output buffer and
// sets the length limit to 2147483647.
`timescale 1ns / 1ps

module content_length_deframer_core #(
  parameter int MAX_VALUE_CHARS = 64,
  parameter int LENGTH_BITS     = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_body_byte,
  output logic                           out_frame_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cld_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic              in_fire;
  logic              out_take;
  logic              cfg_write;
  logic [30:0]       max_len_r;
  cld_pkg::result_t  res;
  cld_pkg::result_t  out_r;
  cld_pkg::result_t  out_nxt;
  cld_pkg::result_t  skid_r;
  cld_pkg::result_t  skid_nxt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == cld_pkg::REG_MAX_BODY_LEN);
  assign prdata    = (paddr[2] == cld_pkg::REG_MAX_BODY_LEN) ? {1'b0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= cld_pkg::MAX_BODY_LEN_RST;
    end else if (cfg_write) begin
      max_len_r <= pwdata[30:0];
    end
  end

  assign in_stall = skid_r.valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_take = out_r.valid && !out_stall;

  cld_parser #(
    .MAX_VALUE_CHARS(MAX_VALUE_CHARS),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_byte     (in_byte),
    .max_body_len(max_len_r),
    .res         (res)
  );

  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (!out_r.valid || out_take) begin
      if (skid_r.valid) begin
        out_nxt  = skid_r;
        skid_nxt = res;
      end else begin
        out_nxt = res;
      end
    end else if (res.valid) begin
      skid_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      out_r.valid  <= out_nxt.valid;
      skid_r.valid <= skid_nxt.valid;
    end
    out_r.kind        <= out_nxt.kind;
    out_r.body_byte   <= out_nxt.body_byte;
    out_r.frame_last  <= out_nxt.frame_last;
    skid_r.kind       <= skid_nxt.kind;
    skid_r.body_byte  <= skid_nxt.body_byte;
    skid_r.frame_last <= skid_nxt.frame_last;
  end

  assign out_valid      = out_r.valid;
  assign out_kind       = out_r.kind;
  assign out_body_byte  = out_r.body_byte;
  assign out_frame_last = out_r.frame_last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid |-> out_r.valid)
    else $error("Skid register holds a result while the output register is empty.");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid && out_stall |=> skid_r.valid && out_r.valid)
    else $error("Buffered result lost while the receiver stalled.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_stall |=> out_r.valid && $stable(out_r))
    else $error("Stalled result changed before its transfer.");

endmodule

### rtl/core/cld_parser.sv
// Header parser and body counter: one byte per transfer, one result per byte at most.
`timescale 1ns / 1ps

module cld_parser #(
  parameter int MAX_VALUE_CHARS = 64,
  parameter int LENGTH_BITS     = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic [30:0]       max_body_len,
  output cld_pkg::result_t  res
);

  localparam int CNT_W = $clog2(MAX_VALUE_CHARS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VALUE_CHARS);
  localparam logic [31:0] LEN_CAP = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef struct packed {
    cld_pkg::phase_t        phase;
    logic [1:0]             run;
    logic [3:0]             key_pos;
    logic                   key_match;
    logic                   len_found;
    logic                   neg;
    logic [31:0]            accum;
    logic [CNT_W-1:0]       cnt;
    logic [LENGTH_BITS-1:0] remain;
  } ps_t;

  localparam ps_t FRAME_INIT = '{
    phase:     cld_pkg::PH_KEY,
    run:       2'd0,
    key_pos:   4'd0,
    key_match: 1'b1,
    len_found: 1'b0,
    neg:       1'b0,
    accum:     32'd0,
    cnt:       '0,
    remain:    '0
  };

  ps_t ps_r;
  ps_t ps_nxt;

  logic            is_body;
  logic            prev_cr;
  logic            hdr_end;
  logic            lf_after_cr;
  logic            over_limit;
  logic            fin_body;
  cld_pkg::kind_t  fin_kind;

  // Applies one byte of line content to the header parsing state.
  function automatic ps_t feed(ps_t s, logic [7:0] c);
    ps_t         t;
    logic        first;
    logic [35:0] prod;
    t     = s;
    first = (s.cnt == '0);
    prod  = ({4'b0000, s.accum} << 3) + ({4'b0000, s.accum} << 1) + {32'd0, c[3:0]};
    case (s.phase)
      cld_pkg::PH_KEY: begin
        if (c == cld_pkg::CH_COLON) begin
          if (s.key_match && s.key_pos == cld_pkg::KEY_LEN && !s.len_found) begin
            t.len_found = 1'b1;
            t.neg       = 1'b0;
            t.accum     = 32'd0;
            t.cnt       = '0;
            t.phase     = cld_pkg::PH_SKIP;
          end else begin
            t.phase = cld_pkg::PH_REST;
          end
        end else if (s.key_match && s.key_pos < cld_pkg::KEY_LEN &&
                     cld_pkg::lower_ascii(c) == cld_pkg::key_char(s.key_pos)) begin
          t.key_pos = s.key_pos + 4'd1;
        end else begin
          t.key_match = 1'b0;
        end
      end
      cld_pkg::PH_SKIP, cld_pkg::PH_VALUE: begin
        if (!(s.phase == cld_pkg::PH_SKIP && cld_pkg::is_space(c))) begin
          t.phase = cld_pkg::PH_VALUE;
          if (s.cnt < CNT_MAX) begin
            t.cnt = s.cnt + CNT_W'(1);
          end
          if (first && (c == cld_pkg::CH_PLUS || c == cld_pkg::CH_MINUS)) begin
            t.neg = (c == cld_pkg::CH_MINUS);
          end else if (c inside {[8'h30:8'h39]}) begin
            t.accum = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
          end else begin
            t.phase = cld_pkg::PH_TAIL;
          end
        end
      end
      cld_pkg::PH_TAIL: begin
        if (s.cnt < CNT_MAX) begin
          t.cnt = s.cnt + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  always_comb begin
    is_body     = (ps_r.phase == cld_pkg::PH_BODY);
    prev_cr     = (ps_r.run == 2'd1) || (ps_r.run == 2'd3);
    hdr_end     = !is_body && (in_byte == cld_pkg::CH_LF) && (ps_r.run == 2'd3);
    lf_after_cr = !is_body && (in_byte == cld_pkg::CH_LF) && prev_cr && !hdr_end;
    over_limit  = (ps_r.accum > {1'b0, max_body_len}) || (ps_r.accum > LEN_CAP);
  end

  always_comb begin
    fin_body = 1'b0;
    fin_kind = cld_pkg::KIND_MISSING;
    if (!ps_r.len_found) begin
      fin_kind = cld_pkg::KIND_MISSING;
    end else if (ps_r.cnt >= CNT_MAX) begin
      fin_kind = cld_pkg::KIND_TOO_LONG;
    end else if (ps_r.neg && ps_r.accum != 32'd0) begin
      fin_kind = cld_pkg::KIND_MISSING;
    end else if (over_limit) begin
      fin_kind = cld_pkg::KIND_TOO_LONG;
    end else if (ps_r.accum == 32'd0) begin
      fin_kind = cld_pkg::KIND_EMPTY;
    end else begin
      fin_body = 1'b1;
    end
  end

  always_comb begin
    ps_t s;
    s      = ps_r;
    ps_nxt = ps_r;
    if (in_fire) begin
      if (is_body) begin
        if (ps_r.remain <= LENGTH_BITS'(1)) begin
          ps_nxt = FRAME_INIT;
        end else begin
          ps_nxt.remain = ps_r.remain - LENGTH_BITS'(1);
        end
      end else if (hdr_end) begin
        ps_nxt = FRAME_INIT;
        if (fin_body) begin
          ps_nxt.remain = ps_r.accum[LENGTH_BITS-1:0];
          ps_nxt.phase  = cld_pkg::PH_BODY;
        end
      end else if (lf_after_cr) begin
        ps_nxt.run       = (ps_r.run == 2'd1) ? 2'd2 : 2'd0;
        ps_nxt.phase     = cld_pkg::PH_KEY;
        ps_nxt.key_pos   = 4'd0;
        ps_nxt.key_match = 1'b1;
      end else begin
        if (in_byte == cld_pkg::CH_CR) begin
          s.run = (ps_r.run == 2'd2) ? 2'd3 : 2'd1;
        end else begin
          s.run = 2'd0;
        end
        if (prev_cr) begin
          s = feed(s, cld_pkg::CH_CR);
        end
        if (in_byte != cld_pkg::CH_CR) begin
          s = feed(s, in_byte);
        end
        ps_nxt = s;
      end
    end
  end

  always_comb begin
    res = '0;
    if (in_fire) begin
      if (is_body && ps_r.remain != '0) begin
        res.valid      = 1'b1;
        res.kind       = cld_pkg::KIND_BODY;
        res.body_byte  = in_byte;
        res.frame_last = (ps_r.remain == LENGTH_BITS'(1));
      end else if (hdr_end && !fin_body) begin
        res.valid      = 1'b1;
        res.kind       = fin_kind;
        res.frame_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= FRAME_INIT;
    end else begin
      ps_r <= ps_nxt;
    end
  end

  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r.phase == cld_pkg::PH_BODY |-> ps_r.remain != '0)
    else $error("Body phase entered with zero remaining length.");

  a_key_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r.key_pos <= cld_pkg::KEY_LEN)
    else $error("Key position ran past the key text.");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind != cld_pkg::KIND_BODY |-> res.frame_last && res.body_byte == 8'd0)
    else $error("Non-body result without frame end or with a nonzero byte.");

endmodule

### verif/tb_content_length_deframer_core.sv
// Self-checking testbench for the content-length deframer core with random pacing on both channels.
`timescale 1ns / 1ps

module tb_content_length_deframer_core;

  localparam int VALUE_CHARS_LIMIT = 64;
  localparam int LEN_BITS = 31;
  localparam int STALL_LIMIT = 5000;
  localparam logic [8*14-1:0] KEY_TEXT = "content-length";
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;
  localparam logic [cld_pkg::CFG_ADDR_W-1:0] LIMIT_ADDR =
    {cld_pkg::REG_MAX_BODY_LEN, 2'b00};
  localparam logic [cld_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR =
    {~cld_pkg::REG_MAX_BODY_LEN, 2'b00};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } deframed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_body_byte;
  logic out_frame_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [cld_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic pready;

  logic [7:0] pending_bytes[$];
  deframed_t expected_items[$];
  int bytes_owed = 0;
  int bytes_queued = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  bit sender_calm = 1'b0;
  logic [15:0] stall_bits = 16'h0;
  logic [5:0] stall_tick = 6'd0;

  // Expected parser state and the length limit register.
  cld_pkg::phase_t ph;
  logic [1:0] crlf_run;
  logic [3:0] key_idx;
  logic key_ok;
  logic len_seen;
  logic len_neg;
  logic [31:0] len_acc;
  logic [6:0] len_chars;
  logic [30:0] body_left;
  logic [30:0] max_len_cfg;

  content_length_deframer_core #(
    .MAX_VALUE_CHARS(VALUE_CHARS_LIMIT),
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_body_byte(out_body_byte),
    .out_frame_last(out_frame_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == cld_pkg::CH_SPACE) || (c >= CH_TAB && c <= cld_pkg::CH_CR);
  endfunction

  task automatic restart_line();
    ph = cld_pkg::PH_KEY;
    key_idx = 4'd0;
    key_ok = 1'b1;
  endtask

  task automatic restart_frame();
    restart_line();
    crlf_run = 2'd0;
    len_seen = 1'b0;
    len_neg = 1'b0;
    len_acc = 32'd0;
    len_chars = 7'd0;
    body_left = 31'd0;
  endtask

  task automatic count_value_char();
    if (len_chars < VALUE_CHARS_LIMIT) len_chars = len_chars + 7'd1;
  endtask

  task automatic feed_line_char(input logic [7:0] c);
    logic first;
    logic [31:0] d;
    case (ph)
      cld_pkg::PH_KEY: begin
        if (c == cld_pkg::CH_COLON) begin
          if (key_ok && key_idx == cld_pkg::KEY_LEN && !len_seen) begin
            len_seen = 1'b1;
            len_neg = 1'b0;
            len_acc = 32'd0;
            len_chars = 7'd0;
            ph = cld_pkg::PH_SKIP;
          end else begin
            ph = cld_pkg::PH_REST;
          end
        end else if (key_ok && key_idx < cld_pkg::KEY_LEN &&
                     fold_case(c) == KEY_TEXT[8 * (13 - int'(key_idx)) +: 8]) begin
          key_idx = key_idx + 4'd1;
        end else begin
          key_ok = 1'b0;
        end
      end
      cld_pkg::PH_SKIP, cld_pkg::PH_VALUE: begin
        if (ph == cld_pkg::PH_SKIP && !is_blank(c)) ph = cld_pkg::PH_VALUE;
        if (ph == cld_pkg::PH_VALUE) begin
          first = (len_chars == 7'd0);
          count_value_char();
          if (first && (c == cld_pkg::CH_PLUS || c == cld_pkg::CH_MINUS)) begin
            len_neg = (c == cld_pkg::CH_MINUS);
          end else if (c >= DIGIT_0 && c <= DIGIT_9) begin
            d = {24'd0, c - DIGIT_0};
            if (len_acc > (32'hFFFF_FFFF - d) / 32'd10) len_acc = 32'hFFFF_FFFF;
            else len_acc = len_acc * 32'd10 + d;
          end else begin
            ph = cld_pkg::PH_TAIL;
          end
        end
      end
      cld_pkg::PH_TAIL: count_value_char();
      default: ;
    endcase
  endtask

  task automatic close_header_block();
    logic [31:0] cap;
    logic [31:0] ceiling;
    logic [31:0] len;
    logic [1:0] kind;
    deframed_t item;
    cap = (32'd1 << LEN_BITS) - 32'd1;
    ceiling = {1'b0, max_len_cfg};
    if (ceiling > cap) ceiling = cap;
    len = len_acc;
    if (!len_seen) kind = cld_pkg::KIND_MISSING;
    else if (len_chars >= VALUE_CHARS_LIMIT) kind = cld_pkg::KIND_TOO_LONG;
    else if (len_neg && len_acc != 32'd0) kind = cld_pkg::KIND_MISSING;
    else if (len_acc > ceiling) kind = cld_pkg::KIND_TOO_LONG;
    else if (len_acc == 32'd0) kind = cld_pkg::KIND_EMPTY;
    else kind = cld_pkg::KIND_BODY;
    restart_frame();
    if (kind == cld_pkg::KIND_BODY) begin
      body_left = len[30:0];
      ph = cld_pkg::PH_BODY;
    end else begin
      item.kind = kind;
      item.data = 8'h00;
      item.last = 1'b1;
      expected_items.push_back(item);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic was_cr;
    deframed_t item;
    if (ph == cld_pkg::PH_BODY) begin
      if (body_left == 31'd0) begin
        restart_frame();
      end else begin
        item.kind = cld_pkg::KIND_BODY;
        item.data = b;
        item.last = (body_left == 31'd1);
        expected_items.push_back(item);
        body_left = body_left - 31'd1;
        if (item.last) restart_frame();
      end
    end else begin
      was_cr = (crlf_run == 2'd1) || (crlf_run == 2'd3);
      if (b == cld_pkg::CH_LF && crlf_run == 2'd3) begin
        close_header_block();
      end else if (b == cld_pkg::CH_LF && was_cr) begin
        crlf_run = 2'd2;
        restart_line();
      end else begin
        if (b == cld_pkg::CH_CR) crlf_run = (crlf_run == 2'd2) ? 2'd3 : 2'd1;
        else crlf_run = 2'd0;
        if (was_cr) feed_line_char(cld_pkg::CH_CR);
        if (b != cld_pkg::CH_CR) feed_line_char(b);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    mismatches++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte);
        bytes_owed--;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_byte <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            if (sender_calm) gap_left <= 0;
            else gap_left <= $urandom_range(0, ($urandom_range(0, 3) == 0) ? 16 : 3);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a 16-bit stall pattern, replayed and reloaded each time the 6-bit tick counter wraps.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == 6'd0) begin
      case ($urandom_range(0, 3))
        0: stall_bits <= 16'h0;
        1: stall_bits <= 16'($urandom);
        2: stall_bits <= 16'($urandom & $urandom);
        default: stall_bits <= 16'($urandom | $urandom);
      endcase
    end
    out_stall <= stall_bits[stall_tick[3:0]];
  end

  always @(posedge clk) begin
    deframed_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                  out_kind, out_body_byte, out_frame_last));
      end else begin
        want = expected_items.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
        if (out_body_byte !== want.data)
          report_mismatch($sformatf("body byte %02h, expected %02h", out_body_byte, want.data));
        if (out_frame_last !== want.last)
          report_mismatch($sformatf("frame_last %0b, expected %0b", out_frame_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_owed++;
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_body(input int n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (bytes_owed != 0 || expected_items.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [cld_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == LIMIT_ADDR) max_len_cfg = value[30:0];
  endtask

  function automatic string cased_key();
    string k;
    logic [7:0] ch;
    k = "";
    for (int i = 0; i < 14; i++) begin
      ch = KEY_TEXT[8 * (13 - i) +: 8];
      if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1)) ch = ch - 8'd32;
      k = $sformatf("%s%c", k, ch);
    end
    return k;
  endfunction

  function automatic string broken_key();
    string k;
    int spot;
    logic [7:0] ch;
    k = "";
    spot = $urandom_range(0, 14);
    for (int i = 0; i < 14; i++) begin
      ch = KEY_TEXT[8 * (13 - i) +: 8];
      k = $sformatf("%s%c", k, (i == spot) ? 8'h78 : ch);
    end
    if (spot == 14) k = {k, "s"};
    return k;
  endfunction

  function automatic string filler_line();
    return $sformatf("X-%c%c: %0d\r\n", 8'h61 + $urandom_range(0, 25),
                     8'h61 + $urandom_range(0, 25), $urandom_range(0, 999));
  endfunction

  task automatic push_random_frame();
    string hdr;
    string val;
    longint n;
    int pick;
    int zeros;
    int frame_body_n;
    logic [7:0] ws;
    hdr = "";
    val = "";
    frame_body_n = 0;
    n = 0;
    repeat ($urandom_range(0, 2)) hdr = {hdr, filler_line()};
    repeat ($urandom_range(0, 2)) begin
      ws = $urandom_range(0, 1) ? cld_pkg::CH_SPACE : CH_TAB;
      val = $sformatf("%s%c", val, ws);
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 12);
      if ($urandom_range(0, 5) == 0) val = {val, "+"};
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0) val = {val, "0"};
      val = $sformatf("%s%0d", val, n);
      if ($urandom_range(0, 5) == 0) val = {val, ";x=1"};
      if (n <= max_len_cfg) frame_body_n = int'(n);
    end else if (pick < 66) begin
      val = $sformatf("%s-%0d", val, $urandom_range(1, 999));
    end else if (pick < 72) begin
      case ($urandom_range(0, 2))
        0: val = {val, "-0"};
        1: val = {val, "+0"};
        default: ;
      endcase
    end else if (pick < 78) begin
      if ($urandom_range(0, 1)) val = {val, "-"};
      val = $sformatf("%s%0d", val, $urandom_range(1, 9));
      repeat ($urandom_range(10, 14)) val = $sformatf("%s%0d", val, $urandom_range(0, 9));
    end else if (pick < 84) begin
      zeros = $urandom_range(58, 68);
      repeat (zeros) val = {val, "0"};
      val = {val, "1"};
      if (zeros + 1 < VALUE_CHARS_LIMIT && max_len_cfg != 31'd0) frame_body_n = 1;
    end else if (pick < 90) begin
      val = $sformatf("%s%0d", val, longint'(max_len_cfg) + 1 + $urandom_range(0, 3));
    end
    if (pick < 90) begin
      hdr = $sformatf("%s%s:%s\r\n", hdr, cased_key(), val);
    end else if (pick < 95) begin
      hdr = $sformatf("%s%s:%0d\r\n", hdr, broken_key(), $urandom_range(0, 9));
    end else begin
      n = $urandom_range(1, 6);
      hdr = $sformatf("%s%s:%0d\r\n%s: %0d\r\n", hdr, cased_key(), n, cased_key(),
                      $urandom_range(0, 99));
      if (n <= max_len_cfg) frame_body_n = int'(n);
    end
    if ($urandom_range(0, 3) == 0) hdr = {hdr, filler_line()};
    push_text({hdr, "\r\n"});
    push_body(frame_body_n);
  endtask

  task automatic push_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 5))
        0: b = cld_pkg::CH_CR;
        1: b = cld_pkg::CH_LF;
        2: b = cld_pkg::CH_COLON;
        3: b = cld_pkg::CH_MINUS;
        4: b = 8'h37;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_byte(b);
    end
    push_text("\r\n\r\n");
  endtask

  initial begin
    int round;
    int start;
    logic [31:0] limit_word;
    restart_frame();
    max_len_cfg = cld_pkg::MAX_BODY_LEN_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_text("Content-Length: 3\r\n\r\nabc");
    push_text("content-length:0\r\n\r\n");
    push_text("X: y\r\n\r\n");
    push_text("CONTENT-LENGTH: -5\r\n\r\n");
    push_text("Content-Length: -0\r\n\r\n");
    push_text("Content-Length:+2\r\n\r\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("Content-Length: 99999999999\r\n\r\n");
    push_text("Content-Length: -99999999999\r\n\r\n");
    push_text("Content-Length: ");
    repeat (63) push_byte(DIGIT_0);
    push_text("1\r\n\r\n");
    push_text("Content-Length: ");
    repeat (62) push_byte(DIGIT_0);
    push_text("1\r\n\r\n!");
    push_text("Content-Length: 2\r\nContent-Length: 5\r\n\r\nhi");
    push_text("Content-Length: 1\rx\r\n\r\nQ");
    push_text("Content-Length:\r 2\r\n\r\nok");
    push_text("Content-Length: 1\r\n");
    push_byte(8'h00);
    push_text("\r\n\r\n");
    push_byte(8'h00);
    push_text("Content-Length:\r\n\r\n");
    push_text("Content-Length: 2147483648\r\n\r\n");
    push_text("Content-Length: 4x7\r\n\r\nbody");
    push_text("Content-Lengthy: 3\r\n\r\n");
    push_text("Content-Length:\t\t4\r\n\r\nwxyz");
    push_text("A\nB: c\r\n\r\n");
    push_text("\r\nContent-Length: 1\r\n\r\nZ");

    wait_idle();
    write_cfg(LIMIT_ADDR, 32'h0000_0000);
    push_text("Content-Length: 1\r\n\r\nContent-Length: 0\r\n\r\n");
    wait_idle();
    // A write to an unmapped address must leave the limit at zero.
    write_cfg(UNMAPPED_ADDR, 32'h7FFF_FFFF);
    push_text("Content-Length: 1\r\n\r\n");
    wait_idle();
    write_cfg(LIMIT_ADDR, 32'h0000_0005);
    push_text("Content-Length: 5\r\n\r\n12345Content-Length: 6\r\n\r\n");

    for (round = 0; round < 6; round++) begin
      wait_idle();
      case (round)
        0: limit_word = 32'hFFFF_FFFF;
        1: limit_word = $urandom_range(0, 3);
        2: limit_word = $urandom_range(4, 30);
        3: limit_word = 32'h8000_000A;
        4: limit_word = 32'h0000_0000;
        default: limit_word = $urandom;
      endcase
      write_cfg(LIMIT_ADDR, limit_word);
      sender_calm = (round == 2);
      start = bytes_queued;
      while (bytes_queued - start < 16) begin
        if ($urandom_range(0, 99) < 15) push_noise();
        else push_random_frame();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_items.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/cld_pkg.sv
rtl/core/cld_parser.sv
rtl/core/content_length_deframer_core.sv
verif/tb_content_length_deframer_core.sv
